[design/ptt_pkg.sv]
// Shared constants, command and result codes, and the cell control bundle.
package ptt_pkg;

  // Default table geometry
  localparam int SLOTS_DEF   = 10;
  localparam int ID_BITS_DEF = 8;
  localparam int CNT_W       = 32;

  // Input command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_REG   = 2'd1;
  localparam logic [1:0] CMD_UNREG = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_FIRE   = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  // Millisecond strobe divisors
  localparam int MS_WRAP = 1000;
  localparam int DIV_10  = 10;
  localparam int DIV_20  = 20;
  localparam int DIV_100 = 100;
  localparam int DIV_500 = 500;

  localparam int MS_W  = $clog2(MS_WRAP + 1);
  localparam int R10_W  = $clog2(DIV_10);
  localparam int R20_W  = $clog2(DIV_20);
  localparam int R100_W = $clog2(DIV_100);
  localparam int R500_W = $clog2(DIV_500);

  // Control shared by every cell of the chain
  typedef struct packed {
    logic rotate;   // every cell takes its right neighbor
    logic compact;  // cells at or past the first hole take their right neighbor
    logic drop;     // invalidate entries whose id matches the key
    logic append;   // first free cell takes the new entry
  } ptt_ctrl_t;

endpackage

[design/ptt_cell.sv]
// One timer slot of the chain: valid flag, callback id, period and count.
module ptt_cell #(
  parameter int ID_BITS = ptt_pkg::ID_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ptt_pkg::ptt_ctrl_t        ctrl,
  input  logic                      nb_valid,
  input  logic [ID_BITS-1:0]        nb_id,
  input  logic [ptt_pkg::CNT_W-1:0] nb_period,
  input  logic [ptt_pkg::CNT_W-1:0] nb_count,
  input  logic                      prev_full,
  input  logic                      hole_in,
  input  logic [ID_BITS-1:0]        key,
  input  logic [ptt_pkg::CNT_W-1:0] new_period,
  output logic                      valid,
  output logic [ID_BITS-1:0]        id,
  output logic [ptt_pkg::CNT_W-1:0] period,
  output logic [ptt_pkg::CNT_W-1:0] count,
  output logic                      full_out,
  output logic                      hole_out
);
  import ptt_pkg::*;

  // Pass prefix status to the right neighbor
  assign full_out = prev_full & valid;
  assign hole_out = hole_in | ~valid;

  // Shift, drop or fill this slot
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.rotate || (ctrl.compact && hole_out)) begin
      valid  <= nb_valid;
      id     <= nb_id;
      period <= nb_period;
      count  <= nb_count;
    end else if (ctrl.drop && valid && (id == key)) begin
      valid <= 1'b0;
    end else if (ctrl.append && prev_full && !valid) begin
      valid  <= 1'b1;
      id     <= key;
      period <= new_period;
      count  <= '0;
    end
  end

endmodule

[design/periodic_timer_table.sv]
// Periodic timer table: a ring of timer cells walked past one head unit.
// Tick: the ring rotates slot by slot past the single increment/compare unit at
// its head, then the summary is issued.
// Unregister: one drop, then compaction shifts along the ring, then the status.
// Register and other commands: a status result. One item at a time; output stalls hold the walk.
// Reset clears all slots, the millisecond counter and both handshakes.
module periodic_timer_table #(
  parameter int SLOTS   = ptt_pkg::SLOTS_DEF,
  parameter int ID_BITS = ptt_pkg::ID_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                cmd,
  input  logic [ID_BITS-1:0]        callback_id,
  input  logic [ptt_pkg::CNT_W-1:0] period,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                kind,
  output logic                      status,
  output logic [ID_BITS-1:0]        fired_id,
  output logic                      strobe_1ms,
  output logic                      strobe_10ms,
  output logic                      strobe_20ms,
  output logic                      strobe_100ms,
  output logic                      strobe_500ms,
  output logic                      strobe_1s,
  output logic                      last
);
  import ptt_pkg::*;

  localparam int STEP_W = $clog2(SLOTS + 1);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SLOTS - 1);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_TICK    = 3'd1;
  localparam logic [2:0] ST_SUM     = 3'd2;
  localparam logic [2:0] ST_COMPACT = 3'd3;
  localparam logic [2:0] ST_STAT    = 3'd4;

  logic [2:0]        state;
  logic [STEP_W-1:0] step;
  logic              stat_full;
  logic [MS_W-1:0]   ms_count;
  logic [R10_W-1:0]  r10;
  logic [R20_W-1:0]  r20;
  logic [R100_W-1:0] r100;
  logic [R500_W-1:0] r500;

  ptt_ctrl_t ctrl;
  logic      accept;
  logic      out_free;

  logic               c_valid  [SLOTS];
  logic [ID_BITS-1:0] c_id     [SLOTS];
  logic [CNT_W-1:0]   c_period [SLOTS];
  logic [CNT_W-1:0]   c_count  [SLOTS];
  logic               full_c   [SLOTS+1];
  logic               hole_c   [SLOTS+1];

  logic               tail_valid;
  logic [CNT_W-1:0]   tail_count;
  logic [CNT_W-1:0]   head_cnt1;
  logic               head_fire;
  logic               head_emit;
  logic               table_full;

  assign in_ready   = (state == ST_IDLE) & ~rst;
  assign accept     = in_valid & in_ready;
  assign out_free   = ~out_valid | out_ready;
  assign table_full = full_c[SLOTS];

  assign full_c[0] = 1'b1;
  assign hole_c[0] = 1'b0;

  // Head unit: advance the head slot's count and test it against its period
  assign head_cnt1  = c_count[0] + CNT_W'(1);
  assign head_fire  = c_valid[0] && (head_cnt1 >= c_period[0]);
  assign head_emit  = head_fire && (c_id[0] != '0);
  assign tail_count = head_fire ? '0 : (c_valid[0] ? head_cnt1 : c_count[0]);
  assign tail_valid = ctrl.rotate ? c_valid[0] : 1'b0;

  // Cell controls
  always_comb begin
    ctrl = '0;
    ctrl.rotate  = (state == ST_TICK) && out_free;
    ctrl.compact = (state == ST_COMPACT);
    ctrl.drop    = accept && (cmd == CMD_UNREG);
    ctrl.append  = accept && (cmd == CMD_REG);
  end

  // Chain of slot cells; the last cell takes the head entry back on rotation
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    logic               nb_valid;
    logic [ID_BITS-1:0] nb_id;
    logic [CNT_W-1:0]   nb_period;
    logic [CNT_W-1:0]   nb_count;

    if (i == SLOTS - 1) begin : g_tail
      assign nb_valid  = tail_valid;
      assign nb_id     = c_id[0];
      assign nb_period = c_period[0];
      assign nb_count  = tail_count;
    end else begin : g_body
      assign nb_valid  = c_valid[i+1];
      assign nb_id     = c_id[i+1];
      assign nb_period = c_period[i+1];
      assign nb_count  = c_count[i+1];
    end

    ptt_cell #(.ID_BITS(ID_BITS)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .nb_valid   (nb_valid),
      .nb_id      (nb_id),
      .nb_period  (nb_period),
      .nb_count   (nb_count),
      .prev_full  (full_c[i]),
      .hole_in    (hole_c[i]),
      .key        (callback_id),
      .new_period (period),
      .valid      (c_valid[i]),
      .id         (c_id[i]),
      .period     (c_period[i]),
      .count      (c_count[i]),
      .full_out   (full_c[i+1]),
      .hole_out   (hole_c[i+1])
    );
  end

  // Sequencer and millisecond counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      stat_full <= 1'b0;
      ms_count  <= '0;
      r10       <= '0;
      r20       <= '0;
      r100      <= '0;
      r500      <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            step      <= '0;
            stat_full <= 1'b0;
            case (cmd)
              CMD_TICK:  state <= ST_TICK;
              CMD_REG: begin
                stat_full <= table_full;
                state     <= ST_STAT;
              end
              CMD_UNREG: state <= ST_COMPACT;
              default:   state <= ST_STAT;
            endcase
          end
        end
        ST_TICK: begin
          if (out_free) begin
            step <= step + STEP_W'(1);
            if (step == STEP_LAST) begin
              state <= ST_SUM;
            end
          end
        end
        ST_SUM: begin
          if (out_free) begin
            r10   <= (r10 == R10_W'(DIV_10 - 1)) ? '0 : r10 + R10_W'(1);
            r20   <= (r20 == R20_W'(DIV_20 - 1)) ? '0 : r20 + R20_W'(1);
            r100  <= (r100 == R100_W'(DIV_100 - 1)) ? '0 : r100 + R100_W'(1);
            r500  <= (r500 == R500_W'(DIV_500 - 1)) ? '0 : r500 + R500_W'(1);
            ms_count <= (ms_count == MS_W'(MS_WRAP - 1)) ? '0 : ms_count + MS_W'(1);
            state <= ST_IDLE;
          end
        end
        ST_COMPACT: begin
          step <= step + STEP_W'(1);
          if (step == STEP_LAST) begin
            state <= ST_STAT;
          end
        end
        ST_STAT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register: hold a result until its transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= 1'b0;
      if ((state == ST_TICK) && head_emit) begin
        out_valid    <= 1'b1;
        kind         <= KIND_FIRE;
        status       <= 1'b0;
        fired_id     <= c_id[0];
        strobe_1ms   <= 1'b0;
        strobe_10ms  <= 1'b0;
        strobe_20ms  <= 1'b0;
        strobe_100ms <= 1'b0;
        strobe_500ms <= 1'b0;
        strobe_1s    <= 1'b0;
        last         <= 1'b0;
      end else if (state == ST_SUM) begin
        out_valid    <= 1'b1;
        kind         <= KIND_TICK;
        status       <= 1'b0;
        fired_id     <= '0;
        strobe_1ms   <= 1'b1;
        strobe_10ms  <= (r10 == R10_W'(DIV_10 - 1));
        strobe_20ms  <= (r20 == R20_W'(DIV_20 - 1));
        strobe_100ms <= (r100 == R100_W'(DIV_100 - 1));
        strobe_500ms <= (r500 == R500_W'(DIV_500 - 1));
        strobe_1s    <= (ms_count == MS_W'(MS_WRAP - 1));
        last         <= 1'b1;
      end else if (state == ST_STAT) begin
        out_valid    <= 1'b1;
        kind         <= KIND_STATUS;
        status       <= stat_full;
        fired_id     <= '0;
        strobe_1ms   <= 1'b0;
        strobe_10ms  <= 1'b0;
        strobe_20ms  <= 1'b0;
        strobe_100ms <= 1'b0;
        strobe_500ms <= 1'b0;
        strobe_1s    <= 1'b0;
        last         <= 1'b1;
      end
    end
  end

endmodule

[bench/tb_periodic_timer_table.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the periodic timer table: predicted results vs. DUT output.
module tb_periodic_timer_table;
  import ptt_pkg::*;

  localparam int SLOTS = SLOTS_DEF;
  localparam int ID_W  = ID_BITS_DEF;

  // Command code the block does not define; it must answer a plain status
  localparam logic [1:0] CMD_UNDEF = 2'd3;

  // One result transaction as seen on the output channel
  typedef struct packed {
    logic [1:0]      kind;
    logic            status;
    logic [ID_W-1:0] fired_id;
    logic            strobe_1ms;
    logic            strobe_10ms;
    logic            strobe_20ms;
    logic            strobe_100ms;
    logic            strobe_500ms;
    logic            strobe_1s;
    logic            last;
  } timer_result_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        cmd;
  logic [ID_W-1:0]   callback_id;
  logic [CNT_W-1:0]  period;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        kind;
  logic              status;
  logic [ID_W-1:0]   fired_id;
  logic              strobe_1ms;
  logic              strobe_10ms;
  logic              strobe_20ms;
  logic              strobe_100ms;
  logic              strobe_500ms;
  logic              strobe_1s;
  logic              last;

  // Shadow copy of the timer table and the millisecond counter
  logic [ID_W-1:0]  tbl_id     [SLOTS] = '{default: '0};
  logic [CNT_W-1:0] tbl_period [SLOTS] = '{default: '0};
  logic [CNT_W-1:0] tbl_count  [SLOTS] = '{default: '0};
  int               tbl_used = 0;
  int               ms_now   = 0;

  timer_result_t pending_results[$];
  int            mismatches = 0;
  bit            no_idle    = 1'b0;

  periodic_timer_table u_top (
    .clk, .rst, .in_valid, .in_ready, .cmd, .callback_id, .period,
    .out_valid, .out_ready, .kind, .status, .fired_id,
    .strobe_1ms, .strobe_10ms, .strobe_20ms, .strobe_100ms, .strobe_500ms,
    .strobe_1s, .last
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("** periodic_timer_table: FAILED **");
    $finish;
  end

  task automatic report_mismatch(input string what);
    if (mismatches < 100) $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // Advance the shadow table by one accepted transaction and queue its results
  task automatic predict_timer_item(input logic [1:0] c, input logic [ID_W-1:0] id,
                                    input logic [CNT_W-1:0] p);
    timer_result_t r;
    int i;
    int w;
    r = '0;
    r.last = 1'b1;
    case (c)
      CMD_TICK: begin
        for (i = 0; i < tbl_used; i++) begin
          tbl_count[i] = tbl_count[i] + 1'b1;
          if (tbl_count[i] >= tbl_period[i]) begin
            tbl_count[i] = '0;
            // id zero keeps counting but stays silent
            if (tbl_id[i] != '0) begin
              r = '0;
              r.kind = KIND_FIRE;
              r.fired_id = tbl_id[i];
              pending_results.push_back(r);
            end
          end
        end
        ms_now++;
        r = '0;
        r.kind         = KIND_TICK;
        r.strobe_1ms   = 1'b1;
        r.strobe_10ms  = (ms_now % DIV_10) == 0;
        r.strobe_20ms  = (ms_now % DIV_20) == 0;
        r.strobe_100ms = (ms_now % DIV_100) == 0;
        r.strobe_500ms = (ms_now % DIV_500) == 0;
        r.strobe_1s    = (ms_now % MS_WRAP) == 0;
        r.last         = 1'b1;
        if (r.strobe_1s) ms_now = 0;
        pending_results.push_back(r);
      end
      CMD_REG: begin
        r.kind = KIND_STATUS;
        if (tbl_used < SLOTS) begin
          tbl_id[tbl_used]     = id;
          tbl_period[tbl_used] = p;
          tbl_count[tbl_used]  = '0;
          tbl_used++;
        end else begin
          r.status = 1'b1;
        end
        pending_results.push_back(r);
      end
      CMD_UNREG: begin
        // Drop matching entries and close the gaps in order
        w = 0;
        for (i = 0; i < tbl_used; i++) begin
          if (tbl_id[i] != id) begin
            tbl_id[w]     = tbl_id[i];
            tbl_period[w] = tbl_period[i];
            tbl_count[w]  = tbl_count[i];
            w++;
          end
        end
        for (i = w; i < SLOTS; i++) begin
          tbl_id[i]     = '0;
          tbl_period[i] = '0;
          tbl_count[i]  = '0;
        end
        tbl_used = w;
        r.kind = KIND_STATUS;
        pending_results.push_back(r);
      end
      default: begin
        r.kind = KIND_STATUS;
        pending_results.push_back(r);
      end
    endcase
  endtask

  // Predict on input transactions, then check output transactions in order
  always @(posedge clk) begin
    timer_result_t want;
    if (!rst) begin
      if (in_valid && in_ready) predict_timer_item(cmd, callback_id, period);
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d id %0d", kind, fired_id));
        end else begin
          want = pending_results.pop_front();
          check_field("kind", 32'(kind), 32'(want.kind));
          check_field("status", 32'(status), 32'(want.status));
          check_field("fired_id", 32'(fired_id), 32'(want.fired_id));
          check_field("strobe_1ms", 32'(strobe_1ms), 32'(want.strobe_1ms));
          check_field("strobe_10ms", 32'(strobe_10ms), 32'(want.strobe_10ms));
          check_field("strobe_20ms", 32'(strobe_20ms), 32'(want.strobe_20ms));
          check_field("strobe_100ms", 32'(strobe_100ms), 32'(want.strobe_100ms));
          check_field("strobe_500ms", 32'(strobe_500ms), 32'(want.strobe_500ms));
          check_field("strobe_1s", 32'(strobe_1s), 32'(want.strobe_1s));
          check_field("last", 32'(last), 32'(want.last));
        end
      end
    end
  end

  // Stall the result side in short random bursts
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!no_idle && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Present one transaction and hold it until the block takes it
  task automatic send_item(input logic [1:0] c, input logic [ID_W-1:0] id,
                           input logic [CNT_W-1:0] p);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= c;
    callback_id <= id;
    period      <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Mostly ids that are already in play, so unregister finds matches
  function automatic logic [ID_W-1:0] pick_id();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return ID_W'($urandom);
      default: return ID_W'($urandom_range(1, 6));
    endcase
  endfunction

  task automatic test_register_and_fire();
    send_item(CMD_REG, 8'hFF, 32'd0);
    send_item(CMD_REG, 8'h00, 32'd1);
    send_item(CMD_REG, 8'h5A, 32'd3);
    send_item(CMD_REG, 8'hA5, 32'hFFFF_FFFF);
    repeat (4) send_item(CMD_TICK, 8'h00, 32'd0);
    wait_for_results();
  endtask

  task automatic test_unregister_and_undefined();
    send_item(CMD_UNREG, 8'h77, 32'd0);
    send_item(CMD_UNDEF, 8'hFF, 32'hFFFF_FFFF);
    send_item(CMD_UNREG, 8'h00, 32'hFFFF_FFFF);
    wait_for_results();
  endtask

  task automatic test_table_full();
    int n;
    for (n = 1; n <= 8; n++) send_item(CMD_REG, ID_W'(n), 32'd2);
    send_item(CMD_TICK, 8'hFF, 32'hFFFF_FFFF);
    send_item(CMD_UNREG, 8'h5A, 32'd0);
    send_item(CMD_UNREG, 8'hFF, 32'd0);
    send_item(CMD_REG, 8'h5A, 32'h8000_0001);
    wait_for_results();
  endtask

  task automatic test_random_traffic();
    int n;
    int pick;
    logic [CNT_W-1:0] p;
    for (n = 0; n < 125; n++) begin
      pick = $urandom_range(0, 19);
      p = ($urandom_range(0, 7) == 0) ? CNT_W'($urandom) : CNT_W'($urandom_range(0, 6));
      if (pick < 10)      send_item(CMD_TICK, ID_W'($urandom), CNT_W'($urandom));
      else if (pick < 15) send_item(CMD_REG, pick_id(), p);
      else if (pick < 19) send_item(CMD_UNREG, pick_id(), CNT_W'($urandom));
      else                send_item(CMD_UNDEF, ID_W'($urandom), CNT_W'($urandom));
    end
    wait_for_results();
  endtask

  // Tick past the next 20 ms boundary with no stalls on either side
  task automatic test_back_to_back_ticks();
    int n;
    no_idle = 1'b1;
    n = DIV_20 - (ms_now % DIV_20) + 3;
    repeat (n) send_item(CMD_TICK, 8'h00, 32'd0);
    wait_for_results();
  endtask

  initial begin
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    cmd         <= CMD_TICK;
    callback_id <= '0;
    period      <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_register_and_fire();
    test_unregister_and_undefined();
    test_table_full();
    test_random_traffic();
    test_back_to_back_ticks();

    // Let any stray result show up before the verdict
    repeat (2 * SLOTS + 10) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("** periodic_timer_table: PASSED **");
    end else begin
      $display("** periodic_timer_table: FAILED **");
    end
    $finish;
  end

endmodule
